[design/vrs_pkg.sv]
// ----------------------------------------------------------------------------
// vrs_pkg
// Shared types for the variable record stack: result codes, state machine
// states and the control part of a front-to-back command.
// ----------------------------------------------------------------------------
package vrs_pkg;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_DATA     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_e;

  typedef enum logic {
    FRONT_IDLE,
    FRONT_POP_RD
  } front_state_e;

  typedef enum logic {
    BACK_IDLE,
    BACK_RUN
  } back_state_e;

  // is_data: the command streams a record out of the byte store,
  // otherwise it is a single status result
  typedef struct packed {
    logic    is_data;
    status_e status;
  } cmd_ctl_t;

endpackage

[design/vrs_ram.sv]
// ----------------------------------------------------------------------------
// vrs_ram
// Generic single-write, single-read RAM with registered read data. The read
// register holds its value while re_i is low.
// ----------------------------------------------------------------------------
module vrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/vrs_queue.sv]
// ----------------------------------------------------------------------------
// vrs_queue
// Small flop-based FIFO carrying commands from the front to the back.
// ----------------------------------------------------------------------------
module vrs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d;
  logic [PW-1:0]    rd_q, rd_d;
  logic [NW-1:0]    num_q, num_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    num_d = num_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      num_d = num_q + NW'(1);
    end else if (pop_i && !push_i) begin
      num_d = num_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      num_q <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  assign data_o  = slot_q[rd_q];
  assign full_o  = (num_q == NW'(DEPTH));
  assign empty_o = (num_q == '0);

endmodule

[design/vrs_front.sv]
// ----------------------------------------------------------------------------
// vrs_front
// Accepts push bytes and pops, writes the byte store, keeps the record table
// and the stack counters, and issues commands to the back end.
// ----------------------------------------------------------------------------
module vrs_front
  import vrs_pkg::*;
#(
  parameter int MEM_BYTES        = 1024,
  parameter int MAX_RECORDS      = 64,
  parameter int MAX_RECORD_BYTES = 64,
  localparam int AW = $clog2(MEM_BYTES),
  localparam int FW = $clog2(MEM_BYTES + 1),
  localparam int RW = $clog2(MAX_RECORDS),
  localparam int CW = $clog2(MAX_RECORDS + 1),
  localparam int LW = $clog2(MAX_RECORD_BYTES + 2)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          action_i,
  input  logic [7:0]    data_byte_i,
  input  logic          final_byte_i,
  output logic          bs_we_o,
  output logic [AW-1:0] bs_waddr_o,
  output logic [7:0]    bs_wdata_o,
  output logic          cmd_push_o,
  input  logic          cmd_full_i,
  output cmd_ctl_t      cmd_ctl_o,
  output logic [AW-1:0] cmd_start_o,
  output logic [LW-1:0] cmd_len_o,
  output logic [CW-1:0] cmd_count_o,
  input  logic          pop_done_i
);

  front_state_e  state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [LW-1:0] pend_q, pend_d;
  logic          disc_q, disc_d;
  logic          busy_q, busy_d;

  logic          accept;
  logic          tbl_we, tbl_re;
  logic [RW-1:0] tbl_waddr, tbl_raddr;
  logic [AW+LW-1:0] tbl_wdata, tbl_rdata;

  logic          in_room;
  logic [FW:0]   byte_addr;
  logic          no_space;
  logic [LW-1:0] pend_new;
  logic          disc_new;
  logic          tbl_full;

  // pushes and pops both wait while a popped record is still being read,
  // since a new push would overwrite those bytes
  assign in_ready_o = (state_q == FRONT_IDLE) && !cmd_full_i && !busy_q;
  assign accept     = in_valid_i && in_ready_o;

  assign tbl_full  = (count_q >= CW'(MAX_RECORDS));
  assign in_room   = (pend_q < LW'(MAX_RECORD_BYTES));
  assign byte_addr = {1'b0, fill_q} + (FW + 1)'(pend_q);
  assign no_space  = tbl_full || (byte_addr >= (FW + 1)'(MEM_BYTES));
  assign pend_new  = in_room ? pend_q + LW'(1) : LW'(MAX_RECORD_BYTES + 1);
  assign disc_new  = disc_q || (in_room && no_space);

  always_comb begin
    state_d = state_q;
    case (state_q)
      FRONT_IDLE: begin
        if (accept && action_i && (count_q != '0)) begin
          state_d = FRONT_POP_RD;
        end
      end
      FRONT_POP_RD: begin
        state_d = FRONT_IDLE;
      end
      default: begin
        state_d = FRONT_IDLE;
      end
    endcase
  end

  always_comb begin
    count_d        = count_q;
    fill_d         = fill_q;
    pend_d         = pend_q;
    disc_d         = disc_q;
    busy_d         = pop_done_i ? 1'b0 : busy_q;
    bs_we_o        = 1'b0;
    bs_waddr_o     = byte_addr[AW-1:0];
    bs_wdata_o     = data_byte_i;
    tbl_we         = 1'b0;
    tbl_waddr      = count_q[RW-1:0];
    tbl_wdata      = {fill_q[AW-1:0], pend_new};
    tbl_re         = 1'b0;
    tbl_raddr      = RW'(count_q - CW'(1));
    cmd_push_o     = 1'b0;
    cmd_ctl_o      = '{is_data: 1'b0, status: ST_DONE};
    cmd_start_o    = tbl_rdata[AW+LW-1:LW];
    cmd_len_o      = tbl_rdata[LW-1:0];
    cmd_count_o    = count_q;
    case (state_q)
      FRONT_IDLE: begin
        if (accept && !action_i) begin
          bs_we_o = in_room && !no_space && !disc_q;
          pend_d  = pend_new;
          disc_d  = disc_new;
          if (final_byte_i) begin
            cmd_push_o = 1'b1;
            pend_d     = '0;
            disc_d     = 1'b0;
            if (pend_new > LW'(MAX_RECORD_BYTES)) begin
              cmd_ctl_o.status = ST_TOO_LONG;
            end else if (disc_new || tbl_full) begin
              cmd_ctl_o.status = ST_OVERFLOW;
            end else begin
              cmd_ctl_o.status = ST_DONE;
              tbl_we           = 1'b1;
              count_d          = count_q + CW'(1);
              cmd_count_o      = count_q + CW'(1);
              fill_d           = fill_q + FW'(pend_new);
            end
          end
        end else if (accept && action_i) begin
          // a pop abandons any partial record
          pend_d = '0;
          disc_d = 1'b0;
          if (count_q == '0) begin
            cmd_push_o       = 1'b1;
            cmd_ctl_o.status = ST_EMPTY;
          end else begin
            tbl_re = 1'b1;
          end
        end
      end
      FRONT_POP_RD: begin
        cmd_push_o  = 1'b1;
        cmd_ctl_o   = '{is_data: 1'b1, status: ST_DATA};
        cmd_count_o = count_q - CW'(1);
        count_d     = count_q - CW'(1);
        fill_d      = FW'(tbl_rdata[AW+LW-1:LW]);
        busy_d      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRONT_IDLE;
      count_q <= '0;
      fill_q  <= '0;
      pend_q  <= '0;
      disc_q  <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      fill_q  <= fill_d;
      pend_q  <= pend_d;
      disc_q  <= disc_d;
      busy_q  <= busy_d;
    end
  end

  // record table: start address and length of each committed record
  vrs_ram #(
    .WIDTH(AW + LW),
    .DEPTH(MAX_RECORDS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .re_i   (tbl_re),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

endmodule

[design/vrs_back.sv]
// ----------------------------------------------------------------------------
// vrs_back
// Executes commands: sends status results, or streams a popped record from
// the byte store one byte per cycle. The store's read register doubles as
// the output byte register, so a stall simply holds the read.
// ----------------------------------------------------------------------------
module vrs_back
  import vrs_pkg::*;
#(
  parameter int MEM_BYTES        = 1024,
  parameter int MAX_RECORDS      = 64,
  parameter int MAX_RECORD_BYTES = 64,
  localparam int AW = $clog2(MEM_BYTES),
  localparam int CW = $clog2(MAX_RECORDS + 1),
  localparam int LW = $clog2(MAX_RECORD_BYTES + 2)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  input  cmd_ctl_t      cmd_ctl_i,
  input  logic [AW-1:0] cmd_start_i,
  input  logic [LW-1:0] cmd_len_i,
  input  logic [CW-1:0] cmd_count_i,
  output logic          bs_re_o,
  output logic [AW-1:0] bs_raddr_o,
  input  logic [7:0]    bs_rdata_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o,
  output status_e       out_status_o,
  output logic [CW-1:0] out_count_o,
  output logic          pop_done_o
);

  back_state_e   state_q, state_d;
  logic          valid_q, valid_d;
  logic          last_q, last_d;
  logic          is_data_q, is_data_d;
  status_e       status_q, status_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [LW-1:0] rem_q, rem_d;
  logic          adv;

  assign adv = !valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BACK_IDLE: begin
        if (adv && !cmd_empty_i && cmd_ctl_i.is_data && (cmd_len_i != LW'(1))) begin
          state_d = BACK_RUN;
        end
      end
      BACK_RUN: begin
        if (adv && (rem_q == LW'(1))) begin
          state_d = BACK_IDLE;
        end
      end
      default: begin
        state_d = BACK_IDLE;
      end
    endcase
  end

  always_comb begin
    valid_d    = valid_q;
    last_d     = last_q;
    is_data_d  = is_data_q;
    status_d   = status_q;
    count_d    = count_q;
    addr_d     = addr_q;
    rem_d      = rem_q;
    cmd_pop_o  = 1'b0;
    bs_re_o    = 1'b0;
    bs_raddr_o = addr_q;
    pop_done_o = 1'b0;
    case (state_q)
      BACK_IDLE: begin
        if (adv) begin
          valid_d = !cmd_empty_i;
          if (!cmd_empty_i) begin
            cmd_pop_o = 1'b1;
            status_d  = cmd_ctl_i.status;
            is_data_d = cmd_ctl_i.is_data;
            count_d   = cmd_count_i;
            last_d    = 1'b1;
            if (cmd_ctl_i.is_data) begin
              bs_re_o    = 1'b1;
              bs_raddr_o = cmd_start_i;
              last_d     = (cmd_len_i == LW'(1));
              pop_done_o = (cmd_len_i == LW'(1));
              addr_d     = cmd_start_i + AW'(1);
              rem_d      = cmd_len_i - LW'(1);
            end
          end
        end
      end
      BACK_RUN: begin
        if (adv) begin
          bs_re_o    = 1'b1;
          valid_d    = 1'b1;
          last_d     = (rem_q == LW'(1));
          pop_done_o = (rem_q == LW'(1));
          addr_d     = addr_q + AW'(1);
          rem_d      = rem_q - LW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BACK_IDLE;
      valid_q   <= 1'b0;
      last_q    <= 1'b0;
      is_data_q <= 1'b0;
      status_q  <= ST_DONE;
      count_q   <= '0;
      addr_q    <= '0;
      rem_q     <= '0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      last_q    <= last_d;
      is_data_q <= is_data_d;
      status_q  <= status_d;
      count_q   <= count_d;
      addr_q    <= addr_d;
      rem_q     <= rem_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = is_data_q ? bs_rdata_i : 8'd0;
  assign out_last_o   = last_q;
  assign out_status_o = status_q;
  assign out_count_o  = count_q;

endmodule

[design/variable_record_stack.sv]
// ----------------------------------------------------------------------------
// variable_record_stack
// LIFO stack of variable-length byte records held in a fixed byte store.
// ----------------------------------------------------------------------------
//   channel   dir  tdata                          tuser        tlast
//   s_axis    in   [7:0] data_byte                [0] action   final_byte
//   m_axis    out  [7:0] out_byte,                [2:0] status last_of_run
//                  [14:8] records_held
//
// A pop passes the front end's idle and pop-read states (record table
// read), then its bytes leave one per cycle from the byte store read port
// while the output is not stalled; input is held off until the last byte
// has been read. Status results pass through a CMD_DEPTH command queue.
// Reset clears all counters at once; the stores need no clearing pass.
// Output stalls hold the store read and back up through the queue.
// ----------------------------------------------------------------------------
module variable_record_stack
  import vrs_pkg::*;
#(
  parameter int MEM_BYTES        = 1024,
  parameter int MAX_RECORDS      = 64,
  parameter int MAX_RECORD_BYTES = 64,
  parameter int CMD_DEPTH        = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] action
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [14:8] records_held
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  output logic        m_axis_tlast
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int LW = $clog2(MAX_RECORD_BYTES + 2);
  localparam int CTLW = $bits(cmd_ctl_t);
  localparam int QW = CTLW + AW + LW + CW;

  logic          bs_we, bs_re;
  logic [AW-1:0] bs_waddr, bs_raddr;
  logic [7:0]    bs_wdata, bs_rdata;

  logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_ctl_t      f_ctl, b_ctl;
  logic [AW-1:0] f_start, b_start;
  logic [LW-1:0] f_len, b_len;
  logic [CW-1:0] f_count, b_count;
  logic [QW-1:0] q_wdata, q_rdata;
  logic          pop_done;

  logic [7:0]    out_byte;
  status_e       out_status;
  logic [CW-1:0] out_count;

  vrs_front #(
    .MEM_BYTES       (MEM_BYTES),
    .MAX_RECORDS     (MAX_RECORDS),
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser[0]),
    .data_byte_i (s_axis_tdata),
    .final_byte_i(s_axis_tlast),
    .bs_we_o     (bs_we),
    .bs_waddr_o  (bs_waddr),
    .bs_wdata_o  (bs_wdata),
    .cmd_push_o  (cmd_push),
    .cmd_full_i  (cmd_full),
    .cmd_ctl_o   (f_ctl),
    .cmd_start_o (f_start),
    .cmd_len_o   (f_len),
    .cmd_count_o (f_count),
    .pop_done_i  (pop_done)
  );

  assign q_wdata = {f_ctl, f_start, f_len, f_count};
  assign {b_ctl, b_start, b_len, b_count} = q_rdata;

  vrs_queue #(
    .WIDTH(QW),
    .DEPTH(CMD_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (q_wdata),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (q_rdata),
    .empty_o(cmd_empty)
  );

  vrs_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (bs_we),
    .waddr_i(bs_waddr),
    .wdata_i(bs_wdata),
    .re_i   (bs_re),
    .raddr_i(bs_raddr),
    .rdata_o(bs_rdata)
  );

  vrs_back #(
    .MEM_BYTES       (MEM_BYTES),
    .MAX_RECORDS     (MAX_RECORDS),
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .cmd_ctl_i   (b_ctl),
    .cmd_start_i (b_start),
    .cmd_len_i   (b_len),
    .cmd_count_i (b_count),
    .bs_re_o     (bs_re),
    .bs_raddr_o  (bs_raddr),
    .bs_rdata_i  (bs_rdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (out_byte),
    .out_last_o  (m_axis_tlast),
    .out_status_o(out_status),
    .out_count_o (out_count),
    .pop_done_o  (pop_done)
  );

  assign m_axis_tdata = {1'b0, 7'(out_count), out_byte};
  assign m_axis_tuser = out_status;

  // the front never writes the store while a popped record is still read
  a_no_store_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(bs_we && bs_re))
    else $error("byte store written while a pop reads it");

  // the end of a pop coincides with the read of its last byte
  a_done_with_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_done |-> bs_re)
    else $error("pop done without a store read");

  // the front only issues commands when the queue has room
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmd_full)
    else $error("command pushed into a full queue");

endmodule

[tb/sv/variable_record_stack_test.sv]
// ----------------------------------------------------------------------------
// variable_record_stack_test
// Drives byte pushes and record pops into the record stack. A predictor with
// its own byte store and record table works out each status or popped byte.
// Results are checked in order, under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module variable_record_stack_test;
  import vrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_BYTES        = 1024;
  localparam int MAX_RECORDS      = 64;
  localparam int MAX_RECORD_BYTES = 64;
  localparam int CYCLE_LIMIT      = 800000;
  localparam int DRAIN_CYCLES     = 32;
  localparam bit ACT_PUSH         = 1'b0;
  localparam bit ACT_POP          = 1'b1;

  typedef struct packed {
    logic       act;
    logic [7:0] data;
    logic       fin;
  } stack_op_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    status_e    status;
    logic [6:0] held;
  } stack_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  stack_op_t     op_queue[$];
  stack_result_t result_queue[$];
  int            op_total;
  int            issued_cnt;
  int            accepted_cnt;
  int            err_cnt;
  int            cycle_cnt;
  int            send_idle_pct;
  int            recv_stall_pct;

  // predictor state
  logic [7:0] mem_model[MEM_BYTES];
  int         rec_base[MAX_RECORDS];
  int         rec_len[MAX_RECORDS];
  int         rec_cnt;
  int         fill_ptr;
  int         pend_len;
  bit         dropping;

  always #1 clk_i = ~clk_i;

  variable_record_stack u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 40) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(15);
    if (r == 0) begin
      return 8'h00;
    end
    if (r == 1) begin
      return 8'hFF;
    end
    return 8'($urandom);
  endfunction

  task automatic add_op(input bit act, input logic [7:0] data, input bit fin);
    stack_op_t op;
    op.act  = act;
    op.data = data;
    op.fin  = fin;
    op_queue.push_back(op);
  endtask

  task automatic add_record(input int len);
    for (int i = 0; i < len; i++) begin
      add_op(ACT_PUSH, pick_byte(), i == len - 1);
    end
  endtask

  task automatic add_pops(input int n);
    for (int i = 0; i < n; i++) begin
      add_op(ACT_POP, 8'($urandom), 1'($urandom));
    end
  endtask

  // Random mix: mostly whole records and pops, some abandoned partials and noise
  task automatic add_mix(input int n);
    int start;
    int r;
    int len;
    start = op_queue.size();
    while (op_queue.size() - start < n) begin
      r = $urandom_range(99);
      if (r < 55) begin
        len = $urandom_range(99);
        if (len < 65) begin
          add_record($urandom_range(6, 1));
        end else if (len < 85) begin
          add_record($urandom_range(63, 7));
        end else if (len < 92) begin
          add_record(MAX_RECORD_BYTES);
        end else begin
          add_record($urandom_range(90, MAX_RECORD_BYTES + 1));
        end
      end else if (r < 80) begin
        add_pops(1);
      end else if (r < 88) begin
        len = $urandom_range(5, 1);
        for (int i = 0; i < len; i++) begin
          add_op(ACT_PUSH, pick_byte(), 1'b0);
        end
      end else begin
        add_op(1'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  function automatic stack_result_t make_result(input logic [7:0] b, input bit last,
                                                input status_e st);
    stack_result_t res;
    res.out_byte = b;
    res.last     = last;
    res.status   = st;
    res.held     = 7'(rec_cnt);
    return res;
  endfunction

  task automatic predict_stack(input stack_op_t op);
    int      addr;
    int      base;
    status_e st;
    if (op.act == ACT_PUSH) begin
      if (pend_len < MAX_RECORD_BYTES) begin
        addr = fill_ptr + pend_len;
        if (rec_cnt >= MAX_RECORDS || addr >= MEM_BYTES) begin
          dropping = 1'b1;
        end else if (!dropping) begin
          mem_model[addr] = op.data;
        end
        pend_len++;
      end else begin
        pend_len = MAX_RECORD_BYTES + 1;
      end
      if (op.fin) begin
        if (pend_len > MAX_RECORD_BYTES) begin
          st = ST_TOO_LONG;
        end else if (dropping || rec_cnt >= MAX_RECORDS) begin
          st = ST_OVERFLOW;
        end else begin
          rec_base[rec_cnt] = fill_ptr;
          rec_len[rec_cnt]  = pend_len;
          rec_cnt++;
          fill_ptr += pend_len;
          st = ST_DONE;
        end
        pend_len = 0;
        dropping = 1'b0;
        result_queue.push_back(make_result(8'h00, 1'b1, st));
      end
    end else begin
      // a pop abandons any partial record silently
      pend_len = 0;
      dropping = 1'b0;
      if (rec_cnt == 0) begin
        result_queue.push_back(make_result(8'h00, 1'b1, ST_EMPTY));
      end else begin
        rec_cnt--;
        base     = rec_base[rec_cnt];
        fill_ptr = base;
        for (int i = 0; i < rec_len[rec_cnt]; i++) begin
          result_queue.push_back(make_result(mem_model[base + i],
                                             i == rec_len[rec_cnt] - 1, ST_DATA));
        end
      end
    end
  endtask

  // Idle mix follows progress through the stimulus
  always_comb begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    if (op_total != 0) begin
      case ((issued_cnt * 4) / op_total)
        0: begin
        end
        1: begin
          send_idle_pct = 62;
        end
        2: begin
          recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct  = 32;
          recv_stall_pct = 32;
        end
      endcase
    end
  end

  // Driver
  always @(posedge clk_i) begin
    stack_op_t op;
    if (s_axis_tvalid && s_axis_tready) begin
      accepted_cnt++;
    end
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        op = op_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op.act;
        s_axis_tdata  <= op.data;
        s_axis_tlast  <= op.fin;
        // order of acceptance is order of issue, so predict now
        predict_stack(op);
        issued_cnt++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    stack_result_t got;
    stack_result_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      got.out_byte = m_axis_tdata[7:0];
      got.last     = m_axis_tlast;
      got.status   = status_e'(m_axis_tuser);
      got.held     = m_axis_tdata[14:8];
      if (result_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction byte=%02h status=%0d",
                                  got.out_byte, got.status));
      end else begin
        want = result_queue.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf(
            "byte %02h/%02h last %0b/%0b status %0d/%0d held %0d/%0d (got/exp)",
            got.out_byte, want.out_byte, got.last, want.last,
            got.status, want.status, got.held, want.held));
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", result_queue.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rec_cnt  = 0;
    fill_ptr = 0;
    pend_len = 0;
    dropping = 1'b0;

    // directed: empty pop, byte extremes, in-order pop, abandoned partial
    add_op(ACT_POP, 8'hFF, 1'b1);
    add_op(ACT_PUSH, 8'h00, 1'b1);
    add_op(ACT_PUSH, 8'hFF, 1'b1);
    add_op(ACT_PUSH, 8'h00, 1'b0);
    add_op(ACT_PUSH, 8'hA5, 1'b0);
    add_op(ACT_PUSH, 8'hFF, 1'b1);
    add_op(ACT_POP, 8'h00, 1'b0);
    add_op(ACT_PUSH, 8'h5A, 1'b0);
    add_op(ACT_PUSH, 8'hC3, 1'b0);
    add_op(ACT_POP, 8'h00, 1'b1);
    add_op(ACT_POP, 8'h55, 1'b0);
    add_op(ACT_POP, 8'hAA, 1'b1);
    add_op(ACT_PUSH, 8'h80, 1'b1);
    add_op(ACT_POP, 8'h7F, 1'b0);

    add_mix(120);

    // table full: empty the stack, then push past the record limit
    add_pops(MAX_RECORDS + 2);
    for (int i = 0; i < MAX_RECORDS + 2; i++) begin
      add_record(1);
    end
    add_record(MAX_RECORD_BYTES + 1);
    add_pops(4);
    add_record(3);

    add_mix(120);

    op_total = op_queue.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(accepted_cnt == op_total && result_queue.size() == 0)) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
